FILE: design/bcam_pkg.sv
// ============================================================================
// Banked cartridge address mapper package
// Shared transaction types, bank state type, region codes and bank helpers.
// ============================================================================
`default_nettype none

package bcam_pkg;

    localparam int ROM_BANK_BITS = 7;
    localparam int BANK_FIELD_W  = 7;
    localparam int RAM_BANK_W    = 2;
    localparam int OFFSET_W      = 21;

    localparam logic [3:0] REGION_BOOT_ROM  = 4'd0;
    localparam logic [3:0] REGION_CART_ROM  = 4'd1;
    localparam logic [3:0] REGION_VRAM      = 4'd2;
    localparam logic [3:0] REGION_CART_RAM  = 4'd3;
    localparam logic [3:0] REGION_WORK_RAM  = 4'd4;
    localparam logic [3:0] REGION_UPPER_RAM = 4'd5;
    localparam logic [3:0] REGION_IO_REG    = 4'd6;
    localparam logic [3:0] REGION_INT_EN    = 4'd7;
    localparam logic [3:0] REGION_BANK_CTRL = 4'd8;
    localparam logic [3:0] REGION_BOOT_FLAG = 4'd9;

    localparam logic [1:0] CTRL_RAM_ENABLE = 2'd0;
    localparam logic [1:0] CTRL_ROM_BANK   = 2'd1;
    localparam logic [1:0] CTRL_RAM_BANK   = 2'd2;
    localparam logic [1:0] CTRL_MODE       = 2'd3;

    localparam logic [3:0]  RAM_ENABLE_KEY = 4'hA;
    localparam logic [15:0] BOOT_FLAG_ADDR = 16'hFF50;

    typedef struct packed {
        logic        action;
        logic [15:0] address;
        logic [7:0]  wdata;
    } req_t;

    typedef struct packed {
        logic [3:0]          region;
        logic [OFFSET_W-1:0] offset;
        logic                write_strobe;
        logic [7:0]          write_byte;
        logic [7:0]          flag_read_value;
    } rsp_t;

    typedef struct packed {
        logic                     ram_enable;
        logic [ROM_BANK_BITS-1:0] rom_sel;
        logic [RAM_BANK_W-1:0]    ram_bank;
        logic [7:0]               boot_flag;
    } bank_state_t;

    function automatic logic [BANK_FIELD_W-1:0] rom_sel_full(
        input logic [ROM_BANK_BITS-1:0] bank
    );
        logic [BANK_FIELD_W-1:0] full;
        full = '0;
        full[ROM_BANK_BITS-1:0] = bank;
        return full;
    endfunction

endpackage

`default_nettype wire

FILE: design/bcam_bank_regs.sv
// ============================================================================
// Bank control registers
// Holds RAM enable, ROM bank, RAM bank and boot flag, updated by each
// write transaction as it leaves the input register.
// ============================================================================
`default_nettype none

module bcam_bank_regs
    import bcam_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        fire,
    input  wire req_t        req,
    output bank_state_t      state
);

    bank_state_t             state_reg;
    bank_state_t             state_next;
    logic [BANK_FIELD_W-1:0] rom_full;
    logic [BANK_FIELD_W-1:0] rom_new;
    logic [4:0]              rom_low;

    always_comb
    begin
        state_next = state_reg;
        rom_full   = rom_sel_full(state_reg.rom_sel);
        rom_low    = (req.wdata[4:0] == 5'd0) ? 5'd1 : req.wdata[4:0];
        rom_new    = rom_full;
        if (fire && req.action && !req.address[15])
        begin
            case (req.address[14:13])
                CTRL_RAM_ENABLE:
                begin
                    state_next.ram_enable = (req.wdata[3:0] == RAM_ENABLE_KEY);
                end
                CTRL_ROM_BANK:
                begin
                    rom_new = {rom_full[BANK_FIELD_W-1:5], rom_low};
                    state_next.rom_sel = rom_new[ROM_BANK_BITS-1:0];
                end
                CTRL_RAM_BANK:
                begin
                    if (state_reg.ram_enable)
                    begin
                        state_next.ram_bank = req.wdata[RAM_BANK_W-1:0];
                    end
                    else
                    begin
                        rom_new = {req.wdata[1:0], rom_full[4:0]};
                        state_next.rom_sel = rom_new[ROM_BANK_BITS-1:0];
                    end
                end
                CTRL_MODE:
                begin
                    state_next = state_reg;
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end
        if (fire && req.action && (req.address == BOOT_FLAG_ADDR))
        begin
            state_next.boot_flag = req.wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.ram_enable <= 1'b0;
            state_reg.rom_sel    <= ROM_BANK_BITS'(1);
            state_reg.ram_bank   <= '0;
            state_reg.boot_flag  <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

    // The low five ROM bank bits can never select bank zero.
    a_rom_bank_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.rom_sel[4:0] != 5'd0)
        else $error("ROM bank low bits are zero");

    // Bank state only moves when a transaction leaves the input register.
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(state_reg))
        else $error("Bank state changed without a transaction");

    // A write to the boot flag address stores the whole byte.
    a_boot_flag_write: assert property (@(posedge clk) disable iff (!rst_n)
        fire && req.action && (req.address == BOOT_FLAG_ADDR)
        |=> state_reg.boot_flag == $past(req.wdata))
        else $error("Boot flag write lost");

endmodule

`default_nettype wire

FILE: design/bcam_decode.sv
// ============================================================================
// Address decoder
// Maps one bus transaction onto a target region and physical offset using
// the current bank state.
// ============================================================================
`default_nettype none

module bcam_decode
    import bcam_pkg::*;
(
    input  wire req_t        req,
    input  wire bank_state_t state,
    output rsp_t             rsp
);

    logic [15:0] a;

    assign a = req.address;

    always_comb
    begin
        rsp.region          = REGION_INT_EN;
        rsp.offset          = '0;
        rsp.write_strobe    = req.action;
        rsp.write_byte      = req.action ? req.wdata : 8'd0;
        rsp.flag_read_value = 8'd0;
        if (!a[15])
        begin
            if (req.action)
            begin
                rsp.region = REGION_BANK_CTRL;
                rsp.offset = OFFSET_W'(a[14:13]);
            end
            else if ((state.boot_flag == 8'd0) && (a[15:8] == 8'd0))
            begin
                rsp.region = REGION_BOOT_ROM;
                rsp.offset = OFFSET_W'(a);
            end
            else if (!a[14])
            begin
                rsp.region = REGION_CART_ROM;
                rsp.offset = OFFSET_W'(a);
            end
            else
            begin
                rsp.region = REGION_CART_ROM;
                rsp.offset = {rom_sel_full(state.rom_sel), a[13:0]};
            end
        end
        else if (a[15:13] == 3'b100)
        begin
            rsp.region = REGION_VRAM;
            rsp.offset = OFFSET_W'(a[12:0]);
        end
        else if (a[15:13] == 3'b101)
        begin
            rsp.region = REGION_CART_RAM;
            rsp.offset = OFFSET_W'({state.ram_bank, a[12:0]});
        end
        else if (a[15:13] == 3'b110)
        begin
            rsp.region = REGION_WORK_RAM;
            rsp.offset = OFFSET_W'(a[12:0]);
        end
        else if (a[15:8] != 8'hFF)
        begin
            rsp.region = REGION_UPPER_RAM;
            rsp.offset = OFFSET_W'(a[12:0]);
        end
        else if (a == BOOT_FLAG_ADDR)
        begin
            rsp.region = REGION_BOOT_FLAG;
            rsp.flag_read_value = req.action ? 8'd0 : state.boot_flag;
        end
        else if (!a[7])
        begin
            rsp.region = REGION_IO_REG;
            rsp.offset = OFFSET_W'(a[7:0]);
        end
        else if (a != 16'hFFFF)
        begin
            rsp.region = REGION_UPPER_RAM;
            rsp.offset = OFFSET_W'(a[12:0]);
        end
        else
        begin
            rsp.region = REGION_INT_EN;
        end
    end

endmodule

`default_nettype wire

FILE: design/banked_cartridge_address_mapper.sv
// ============================================================================
// Banked cartridge address mapper
// Decodes CPU bus transactions into region and offset and keeps the
// cartridge bank control registers.
// ============================================================================
//
// Channel   Ports                      Contents
// request   req_valid, req_stall, req  action, address, wdata
// response  rsp_valid, rsp_stall, rsp  region, offset, strobe, byte, flag
//
// A transaction is registered on acceptance, decoded in the next cycle and
// its response registered; one transaction per cycle while the response is not stalled.
// The bank registers update as the transaction moves to the response
// register, so the following transaction sees the new bank state.
// A stalled response holds the input register, which then stalls the request.
// Reset clears both valid flags and loads the bank registers.
// ============================================================================
`default_nettype none

module banked_cartridge_address_mapper
    import bcam_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    logic        s1_valid_reg;
    logic        s1_valid_next;
    req_t        s1_req_reg;
    logic        rsp_valid_reg;
    logic        rsp_valid_next;
    rsp_t        rsp_reg;
    rsp_t        rsp_next;
    bank_state_t state;
    logic        rsp_open;
    logic        advance;
    logic        accept;

    assign rsp_open       = !rsp_valid_reg || !rsp_stall;
    assign advance        = s1_valid_reg && rsp_open;
    assign req_stall      = s1_valid_reg && !rsp_open;
    assign accept         = req_valid && !req_stall;
    assign s1_valid_next  = accept || (s1_valid_reg && !advance);
    assign rsp_valid_next = advance || (rsp_valid_reg && rsp_stall);

    bcam_bank_regs u_bank_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .req   (s1_req_reg),
        .state (state)
    );

    bcam_decode u_decode (
        .req   (s1_req_reg),
        .state (state),
        .rsp   (rsp_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg <= req;
        end
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // A held input transaction with a stalled response must stall the request.
    a_back_pressure: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && rsp_valid_reg && rsp_stall |-> req_stall)
        else $error("Request accepted while the pipeline is full");

    // A transaction that leaves the input register always yields a response.
    a_advance_response: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> rsp_valid_reg)
        else $error("Transaction advanced without a response");

    // The write strobe of a new response follows the transaction's action.
    a_strobe_match: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> rsp_reg.write_strobe == $past(s1_req_reg.action))
        else $error("Write strobe does not match the transaction");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ============================================================================
// Banked cartridge address mapper testbench
// Drives CPU bus transactions through the request channel and predicts the
// region, offset, write strobe, write byte and boot flag value of every
// response with an independent model of the bank control registers. It
// starts with directed accesses at the map boundaries and the bank register
// corner cases, then runs random transactions in chunks, with random idle
// cycles on the request side and random stalls on the response side.
// ============================================================================
`default_nettype none

module testbench;
    import bcam_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 11;
    localparam int RANDOM_ITEMS  = 950;
    localparam int CHUNK         = 190;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 10;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    localparam logic [6:0] BANK_MASK = 7'((1 << ROM_BANK_BITS) - 1);

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    req_t req       = '0;
    logic rsp_stall = 1'b0;
    logic req_stall;
    logic rsp_valid;
    rsp_t rsp;

    req_t pending_q[$];
    rsp_t expected_q[$];

    logic       map_ram_en    = 1'b0;
    logic [6:0] map_rom_sel   = 7'd1 & BANK_MASK;
    logic [1:0] map_ram_bank  = 2'd0;
    logic [7:0] map_boot_flag = 8'd0;

    logic req_taken  = 1'b0;
    logic bus_idle   = 1'b0;
    logic rx_stalled = 1'b0;
    int   send_gap   = 0;
    int   stall_left = 0;

    int cycle_count    = 0;
    int mismatch_count = 0;
    int sent_count     = 0;
    int checked_count  = 0;
    int control_writes = 0;
    int region_hits[16];

    banked_cartridge_address_mapper i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    function automatic rsp_t map_access(input req_t a);
        rsp_t       r;
        logic [1:0] ctrl;
        logic [4:0] low;
        r = '0;
        ctrl = a.address[14:13];
        r.write_strobe = a.action;
        r.write_byte = (a.action == ACT_WRITE) ? a.wdata : 8'h00;
        if (a.address < 16'h8000)
        begin
            if (a.action == ACT_WRITE)
            begin
                r.region = REGION_BANK_CTRL;
                r.offset = OFFSET_W'(ctrl);
                case (ctrl)
                    CTRL_RAM_ENABLE: map_ram_en = (a.wdata[3:0] == RAM_ENABLE_KEY);
                    CTRL_ROM_BANK:
                    begin
                        low = a.wdata[4:0];
                        if (low == 5'd0)
                            low = 5'd1;
                        map_rom_sel = {map_rom_sel[6:5], low} & BANK_MASK;
                    end
                    CTRL_RAM_BANK:
                    begin
                        if (map_ram_en)
                            map_ram_bank = a.wdata[1:0];
                        else
                            map_rom_sel = {a.wdata[1:0], map_rom_sel[4:0]} & BANK_MASK;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (map_boot_flag == 8'h00 && a.address <= 16'h00FF)
            begin
                r.region = REGION_BOOT_ROM;
                r.offset = OFFSET_W'(a.address);
            end
            else if (a.address < 16'h4000)
            begin
                r.region = REGION_CART_ROM;
                r.offset = OFFSET_W'(a.address);
            end
            else
            begin
                r.region = REGION_CART_ROM;
                r.offset = {map_rom_sel, 14'h0} + OFFSET_W'(a.address - 16'h4000);
            end
        end
        else if (a.address < 16'hA000)
        begin
            r.region = REGION_VRAM;
            r.offset = OFFSET_W'(a.address - 16'h8000);
        end
        else if (a.address < 16'hC000)
        begin
            r.region = REGION_CART_RAM;
            r.offset = OFFSET_W'({map_ram_bank, 13'h0}) + OFFSET_W'(a.address - 16'hA000);
        end
        else if (a.address < 16'hE000)
        begin
            r.region = REGION_WORK_RAM;
            r.offset = OFFSET_W'(a.address - 16'hC000);
        end
        else if (a.address < 16'hFF00)
        begin
            r.region = REGION_UPPER_RAM;
            r.offset = OFFSET_W'(a.address - 16'hE000);
        end
        else if (a.address == BOOT_FLAG_ADDR)
        begin
            r.region = REGION_BOOT_FLAG;
            if (a.action == ACT_WRITE)
                map_boot_flag = a.wdata;
            else
                r.flag_read_value = map_boot_flag;
        end
        else if (a.address < 16'hFF80)
        begin
            r.region = REGION_IO_REG;
            r.offset = OFFSET_W'(a.address - 16'hFF00);
        end
        else if (a.address < 16'hFFFF)
        begin
            r.region = REGION_UPPER_RAM;
            r.offset = OFFSET_W'(a.address - 16'hE000);
        end
        else
        begin
            r.region = REGION_INT_EN;
        end
        return r;
    endfunction

    function automatic req_t make_bus_access();
        req_t a;
        int   pick;
        a.action  = 1'($urandom);
        a.address = 16'($urandom);
        a.wdata   = 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 25)
        begin
            a.action = ACT_WRITE;
            a.address[15] = 1'b0;
            if (a.address[14:13] == CTRL_RAM_ENABLE && $urandom_range(1) == 1)
                a.wdata[3:0] = RAM_ENABLE_KEY;
        end
        else if (pick < 45)
        begin
            a.action = ACT_READ;
            a.address[15] = 1'b0;
            if ($urandom_range(2) == 0)
                a.address[14:8] = '0;
        end
        else if (pick < 55)
        begin
            a.address[15:13] = 3'b101;
        end
        else if (pick < 62)
        begin
            a.address = BOOT_FLAG_ADDR;
            if ($urandom_range(1) == 1)
                a.wdata = 8'h00;
        end
        else if (pick < 67)
        begin
            a.address[15:8] = 8'hFF;
        end
        else if (pick < 70)
        begin
            a.address = 16'hFFFF;
        end
        return a;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return 0;
        else if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("MISMATCH response %0d %s: got 0x%0h, expected 0x%0h",
                 checked_count, what, got, want);
    endtask

    task automatic push_access(input logic action, input logic [15:0] address,
                               input logic [7:0] wdata);
        req_t a;
        a.action  = action;
        a.address = address;
        a.wdata   = wdata;
        pending_q.push_back(a);
    endtask

    task automatic wait_drained();
        @(posedge clk);
        @(negedge clk);
        while (!bus_idle)
            @(negedge clk);
    endtask

    always @(posedge clk)
    begin : monitor
        rsp_t want;
        if (rst_n)
        begin
            req_taken = req_valid && !req_stall;
            if (req_taken)
            begin
                want = map_access(req);
                expected_q.push_back(want);
                region_hits[want.region]++;
                if (want.region == REGION_BANK_CTRL)
                    control_writes++;
                sent_count++;
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    report_mismatch("arrived with no transaction outstanding", rsp.region, 0);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (rsp.region !== want.region)
                        report_mismatch("region", rsp.region, want.region);
                    if (rsp.offset !== want.offset)
                        report_mismatch("offset", rsp.offset, want.offset);
                    if (rsp.write_strobe !== want.write_strobe)
                        report_mismatch("write_strobe", rsp.write_strobe, want.write_strobe);
                    if (rsp.write_byte !== want.write_byte)
                        report_mismatch("write_byte", rsp.write_byte, want.write_byte);
                    if (rsp.flag_read_value !== want.flag_read_value)
                        report_mismatch("flag_read_value", rsp.flag_read_value,
                                        want.flag_read_value);
                end
                checked_count++;
            end
            bus_idle = (pending_q.size() == 0) && (expected_q.size() == 0) && !req_valid;
        end
    end

    always @(negedge clk)
    begin : driver
        logic next_valid;
        logic send_quiet;
        logic recv_quiet;
        next_valid = req_valid;
        send_quiet = (cycle_count[10:9] == 2'b11);
        recv_quiet = (cycle_count[10:9] == 2'b01);
        if (rst_n && !(req_valid && !req_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                next_valid = 1'b0;
            end
            else if (pending_q.size() > 0)
            begin
                req <= pending_q.pop_front();
                next_valid = 1'b1;
                send_gap = send_quiet ? 0 : pick_gap();
            end
            else
            begin
                next_valid = 1'b0;
            end
        end
        req_valid <= next_valid;
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left--;
            end
            else
            begin
                rx_stalled = ($urandom_range(99) < 35);
                stall_left = rx_stalled ? pick_gap() : $urandom_range(0, 6);
            end
            rsp_stall <= rx_stalled && !recv_quiet;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Run stopped at the cycle limit with %0d responses outstanding.",
                     expected_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin : stimulus
        int regions_seen;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_access(ACT_READ,  16'h0000, 8'hFF);
        push_access(ACT_READ,  16'h00FF, 8'h00);
        push_access(ACT_READ,  16'h0100, 8'h00);
        push_access(ACT_READ,  16'h4000, 8'h00);
        push_access(ACT_WRITE, 16'h2000, 8'h00);
        push_access(ACT_READ,  16'h7FFF, 8'h00);
        push_access(ACT_WRITE, 16'h3FFF, 8'hFF);
        push_access(ACT_WRITE, 16'h4000, 8'h03);
        push_access(ACT_READ,  16'h7FFF, 8'h00);
        push_access(ACT_WRITE, 16'h0000, 8'h0A);
        push_access(ACT_WRITE, 16'h5FFF, 8'h03);
        push_access(ACT_READ,  16'hBFFF, 8'h00);
        push_access(ACT_WRITE, 16'hA000, 8'hFF);
        push_access(ACT_WRITE, 16'h1FFF, 8'hF5);
        push_access(ACT_READ,  16'hA000, 8'h00);
        push_access(ACT_WRITE, 16'h6000, 8'hFF);
        push_access(ACT_READ,  16'h8000, 8'h00);
        push_access(ACT_WRITE, 16'hDFFF, 8'h55);
        push_access(ACT_READ,  16'hFEFF, 8'h00);
        push_access(ACT_READ,  16'hFF00, 8'h00);
        push_access(ACT_READ,  16'hFF50, 8'h00);
        push_access(ACT_WRITE, 16'hFF50, 8'h80);
        push_access(ACT_READ,  16'hFF50, 8'h00);
        push_access(ACT_READ,  16'h0000, 8'h00);
        push_access(ACT_READ,  16'hFF7F, 8'h00);
        push_access(ACT_READ,  16'hFF80, 8'h00);
        push_access(ACT_WRITE, 16'hFFFF, 8'hAA);
        wait_drained();

        for (int i = 0; i < RANDOM_ITEMS; i += CHUNK)
        begin
            @(posedge clk);
            for (int k = i; k < i + CHUNK && k < RANDOM_ITEMS; k++)
                pending_q.push_back(make_bus_access());
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);

        regions_seen = 0;
        foreach (region_hits[r])
            if (region_hits[r] > 0)
                regions_seen++;
        $display("Covered %0d transactions and %0d responses in %0d cycles.",
                 sent_count, checked_count, cycle_count);
        $display("Hit %0d address regions with %0d bank control writes.",
                 regions_seen, control_writes);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
